// File: rtl/core/cls_pkg.sv
package cls_pkg;

  // Default geometry of the character frame
  localparam int unsigned COLUMNS_DEF = 16;
  localparam int unsigned ROWS_DEF    = 2;

  // Number of LCD init commands before the ready step
  localparam logic [3:0] INIT_STEPS = 4'd11;

  // Request kinds
  typedef enum logic [2:0] {
    KIND_START   = 3'd0,
    KIND_PROCEED = 3'd1,
    KIND_WRITE   = 3'd2,
    KIND_FLUSH   = 3'd3,
    KIND_COLOUR  = 3'd4
  } kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CONTRAST_LOW  = 3'd0,
    REG_CONTRAST_HIGH = 3'd1,
    REG_FIRST_DELAY   = 3'd2,
    REG_BURST_SIZE    = 3'd3,
    REG_CHUNK_DELAY   = 3'd4,
    REG_CMD_CONTROL   = 3'd5,
    REG_RGB_PRESENT   = 3'd6,
    REG_BACKLIGHT     = 3'd7
  } reg_e;

  // Result targets
  typedef enum logic [1:0] {
    TGT_LCD = 2'd0,
    TGT_RGB = 2'd1,
    TGT_EVT = 2'd2
  } target_e;

  // Sequence mode, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_INIT  = 5'b00010,
    MODE_READY = 5'b00100,
    MODE_POS   = 5'b01000,
    MODE_DATA  = 5'b10000
  } mode_e;

  // Byte source select of a microcode step
  typedef enum logic [2:0] {
    BSEL_CONST = 3'd0,
    BSEL_CTRL  = 3'd1,
    BSEL_CMD   = 3'd2,
    BSEL_RED   = 3'd3,
    BSEL_GREEN = 3'd4,
    BSEL_BLUE  = 3'd5,
    BSEL_FB    = 3'd6,
    BSEL_ZERO  = 3'd7
  } bsel_e;

  // Sequencing op of a microcode step
  typedef enum logic [1:0] {
    OP_NEXT = 2'd0,
    OP_END  = 2'd1,
    OP_LOOP = 2'd2
  } op_e;

  // One control word: every step emits one result
  typedef struct packed {
    op_e         op;
    target_e     tgt;
    bsel_e       bsel;
    logic [7:0]  konst;
    logic        eot;
    logic        fin;
  } uword_t;

  localparam int unsigned UA_W = 5;

  // Program entry points
  localparam logic [UA_W-1:0] UA_RGB  = 5'd0;
  localparam logic [UA_W-1:0] UA_COL  = 5'd6;
  localparam logic [UA_W-1:0] UA_CMD  = 5'd12;
  localparam logic [UA_W-1:0] UA_DATA = 5'd14;
  localparam logic [UA_W-1:0] UA_EVT  = 5'd16;

  function automatic uword_t uw(op_e op, target_e tgt, bsel_e bsel, logic [7:0] k,
                                logic eot, logic fin);
    uword_t w;
    w.op    = op;
    w.tgt   = tgt;
    w.bsel  = bsel;
    w.konst = k;
    w.eot   = eot;
    w.fin   = fin;
    return w;
  endfunction

  // Microcode ROM. On a loop step, eot and fin apply to the final pass only.
  function automatic uword_t ucode(logic [UA_W-1:0] a);
    uword_t w;
    unique case (a)
      // backlight chip init: mode1, mode2, output control
      UA_RGB:          w = uw(OP_NEXT, TGT_RGB, BSEL_CONST, 8'h00, 1'b0, 1'b0);
      UA_RGB + 5'd1:   w = uw(OP_NEXT, TGT_RGB, BSEL_CONST, 8'h00, 1'b1, 1'b0);
      UA_RGB + 5'd2:   w = uw(OP_NEXT, TGT_RGB, BSEL_CONST, 8'h01, 1'b0, 1'b0);
      UA_RGB + 5'd3:   w = uw(OP_NEXT, TGT_RGB, BSEL_CONST, 8'h05, 1'b1, 1'b0);
      UA_RGB + 5'd4:   w = uw(OP_NEXT, TGT_RGB, BSEL_CONST, 8'h08, 1'b0, 1'b0);
      UA_RGB + 5'd5:   w = uw(OP_END,  TGT_RGB, BSEL_CONST, 8'hAA, 1'b1, 1'b1);
      // backlight colour: red, green, blue PWM registers
      UA_COL:          w = uw(OP_NEXT, TGT_RGB, BSEL_CONST, 8'h04, 1'b0, 1'b0);
      UA_COL + 5'd1:   w = uw(OP_NEXT, TGT_RGB, BSEL_RED,   8'h00, 1'b1, 1'b0);
      UA_COL + 5'd2:   w = uw(OP_NEXT, TGT_RGB, BSEL_CONST, 8'h03, 1'b0, 1'b0);
      UA_COL + 5'd3:   w = uw(OP_NEXT, TGT_RGB, BSEL_GREEN, 8'h00, 1'b1, 1'b0);
      UA_COL + 5'd4:   w = uw(OP_NEXT, TGT_RGB, BSEL_CONST, 8'h02, 1'b0, 1'b0);
      UA_COL + 5'd5:   w = uw(OP_END,  TGT_RGB, BSEL_BLUE,  8'h00, 1'b1, 1'b1);
      // LCD command: control byte, command byte
      UA_CMD:          w = uw(OP_NEXT, TGT_LCD, BSEL_CTRL,  8'h00, 1'b0, 1'b0);
      UA_CMD + 5'd1:   w = uw(OP_END,  TGT_LCD, BSEL_CMD,   8'h00, 1'b1, 1'b1);
      // LCD data burst: data control byte, then characters
      UA_DATA:         w = uw(OP_NEXT, TGT_LCD, BSEL_CONST, 8'h40, 1'b0, 1'b0);
      UA_DATA + 5'd1:  w = uw(OP_LOOP, TGT_LCD, BSEL_FB,    8'h00, 1'b1, 1'b1);
      // event only result
      UA_EVT:          w = uw(OP_END,  TGT_EVT, BSEL_ZERO,  8'h00, 1'b0, 1'b1);
      default:         w = uw(OP_END,  TGT_EVT, BSEL_ZERO,  8'h00, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

  // LCD init command for each step
  function automatic logic [7:0] init_cmd(logic [3:0] idx, logic [3:0] clow,
                                          logic [1:0] chigh);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h38;
      4'd1:    c = 8'h39;
      4'd2:    c = 8'h14;
      4'd3:    c = {4'h7, clow};
      4'd4:    c = {6'b010111, chigh};
      4'd5:    c = 8'h6C;
      4'd6:    c = 8'h38;
      4'd7:    c = 8'h0C;
      4'd8:    c = 8'h01;
      4'd9:    c = 8'h06;
      default: c = 8'h02;
    endcase
    return c;
  endfunction

  // Delay after each init command; a zero first delay becomes 1 ms
  function automatic logic [7:0] init_dly(logic [3:0] idx, logic [7:0] first);
    logic [7:0] d;
    unique case (idx)
      4'd0:    d = (first == 8'd0) ? 8'd1 : first;
      4'd5:    d = 8'd220;
      4'd8:    d = 8'd3;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/core/char_lcd_i2c_sequencer.sv
// Character LCD sequencer. Keeps a ROWS x COLUMNS frame buffer (reset to
// spaces) and turns requests into bus bytes for a two-wire LCD and an
// optional RGB backlight chip, plus delay requests and ready/flush events.
// A request is taken when start is high and busy is low. A small microcode
// program then runs one step per clock, each step producing one result, and
// busy stays high until the last step (results per request: one LCD command
// 2, backlight init or colour 6, a data burst chunk + 1, at most 17 with
// 16-character bursts). Write-char, ignored and silent requests finish
// in the accept cycle. Results come out of an output register in the cycle
// after their step, each shown for one cycle with strobe_o high; the
// receiver cannot stall them. The frame buffer lives in a RAM with a
// registered read, so data bursts read one character per cycle. The config
// port is always ready and must only be written while the block is idle.
module char_lcd_i2c_sequencer #(
  parameter int unsigned COLUMNS = cls_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = cls_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [3:0]  column_i,
  input  logic        line_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // results
  output logic        strobe_o,
  output logic [1:0]  target_o,
  output logic [7:0]  bus_byte_o,
  output logic        end_of_transfer_o,
  output logic [7:0]  delay_ms_o,
  output logic        ready_event_o,
  output logic        flush_done_o,
  output logic        last_o
);

  localparam int unsigned FB_DEPTH = ROWS * COLUMNS;
  localparam int unsigned FB_AW    = $clog2(FB_DEPTH);
  localparam int unsigned SENT_W   = $clog2(COLUMNS + 1);
  localparam int unsigned ROW_W    = $clog2(ROWS + 1);
  localparam int unsigned CW       = (SENT_W > 5) ? SENT_W : 5;
  localparam int unsigned BMAX     = (COLUMNS < 16) ? COLUMNS : 16;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [3:0]  contrast_low_q;
  logic [1:0]  contrast_high_q;
  logic [7:0]  first_delay_q;
  logic [4:0]  burst_size_q;
  logic [7:0]  chunk_delay_q;
  logic        cmd_control_q;
  logic        rgb_present_q;
  logic [23:0] backlight_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_low_q  <= 4'd8;
      contrast_high_q <= 2'd2;
      first_delay_q   <= 8'd40;
      burst_size_q    <= 5'd16;
      chunk_delay_q   <= 8'd1;
      cmd_control_q   <= 1'b1;
      rgb_present_q   <= 1'b1;
      backlight_q     <= 24'h102040;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cls_pkg::REG_CONTRAST_LOW:  contrast_low_q  <= cfg_data_i[3:0];
        cls_pkg::REG_CONTRAST_HIGH: contrast_high_q <= cfg_data_i[1:0];
        cls_pkg::REG_FIRST_DELAY:   first_delay_q   <= cfg_data_i[7:0];
        cls_pkg::REG_BURST_SIZE:    burst_size_q    <= cfg_data_i[4:0];
        cls_pkg::REG_CHUNK_DELAY:   chunk_delay_q   <= cfg_data_i[7:0];
        cls_pkg::REG_CMD_CONTROL:   cmd_control_q   <= cfg_data_i[0];
        cls_pkg::REG_RGB_PRESENT:   rgb_present_q   <= cfg_data_i[0];
        cls_pkg::REG_BACKLIGHT:     backlight_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  cls_pkg::mode_e        mode_q, mode_d;
  logic [3:0]            init_idx_q, init_idx_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [SENT_W-1:0]     sent_q, sent_d;
  logic                  dirty_q, dirty_d;
  logic                  run_q, run_d;
  logic [cls_pkg::UA_W-1:0] pc_q, pc_d;
  logic [4:0]            cnt_q, cnt_d;
  logic [7:0]            cmd_q, cmd_d;
  logic [7:0]            dly_q, dly_d;
  logic                  rdy_q, rdy_d;
  logic                  fdone_q, fdone_d;
  logic [23:0]           rgb_q, rgb_d;
  logic [FB_AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [FB_DEPTH-1:0]   fb_valid_q;
  logic                  rvalid_q;

  // output register
  logic       strobe_q, strobe_d;
  logic [1:0] target_q, target_d;
  logic [7:0] byte_q, byte_d;
  logic       eot_q, eot_d;
  logic [7:0] delay_q, delay_d;
  logic       rdyev_q, rdyev_d;
  logic       done_q, done_d;
  logic       last_q, last_d;

  logic accept;
  assign busy   = run_q;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------
  // Frame buffer write path
  // ---------------------------------------------------------------------
  logic             fb_we;
  logic [FB_AW-1:0] fb_waddr;
  logic [7:0]       fb_wdata;
  logic [7:0]       fb_rdata;

  assign fb_we = accept && (kind_i == cls_pkg::KIND_WRITE)
                 && (32'(line_i) < ROWS) && (32'(column_i) < COLUMNS);
  assign fb_waddr = FB_AW'(32'(line_i) * COLUMNS + 32'(column_i));
  assign fb_wdata = (char_code_i >= 8'h20 && char_code_i <= 8'h7E) ? char_code_i : 8'h3F;

  cls_ram #(
    .WIDTH (8),
    .DEPTH (FB_DEPTH)
  ) u_fb_ram (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .waddr_i (fb_waddr),
    .wdata_i (fb_wdata),
    .raddr_i (rd_ptr_q),
    .rdata_o (fb_rdata)
  );

  // ---------------------------------------------------------------------
  // Dispatch helpers
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0] pos_row;
  logic [2:0]       pos_row3;
  logic [6:0]       row_addr;
  logic [CW-1:0]    blen, left, chunk, sent_new;
  logic [FB_AW-1:0] base;
  logic [ROW_W-1:0] row_next;

  // flush request starts at row 0, a proceed in position mode uses row_q
  assign pos_row  = (mode_q == cls_pkg::MODE_POS) ? row_q : '0;
  assign pos_row3 = 3'(pos_row);
  assign row_addr = (pos_row3[0] ? 7'h40 : 7'h00) + (pos_row3[1] ? 7'(COLUMNS) : 7'h00);

  // burst clamped to 1..min(16, COLUMNS), then to what is left of the row
  always_comb begin
    if (burst_size_q == 5'd0) begin
      blen = CW'(1);
    end else if (CW'(burst_size_q) > CW'(BMAX)) begin
      blen = CW'(BMAX);
    end else begin
      blen = CW'(burst_size_q);
    end
  end
  assign left     = CW'(COLUMNS) - CW'(sent_q);
  assign chunk    = (blen < left) ? blen : left;
  assign sent_new = CW'(sent_q) + chunk;
  assign base     = FB_AW'(32'(row_q) * COLUMNS + 32'(sent_q));
  assign row_next = row_q + ROW_W'(1);

  // ---------------------------------------------------------------------
  // Microcode step and dispatch
  // ---------------------------------------------------------------------
  cls_pkg::uword_t w;
  logic            loop_last, fin_eff, eot_eff;

  assign w         = cls_pkg::ucode(pc_q);
  assign loop_last = (cnt_q == 5'd1);
  assign fin_eff   = w.fin && ((w.op != cls_pkg::OP_LOOP) || loop_last);
  assign eot_eff   = w.eot && ((w.op != cls_pkg::OP_LOOP) || loop_last);

  always_comb begin
    mode_d     = mode_q;
    init_idx_d = init_idx_q;
    row_d      = row_q;
    sent_d     = sent_q;
    dirty_d    = dirty_q;
    run_d      = run_q;
    pc_d       = pc_q;
    cnt_d      = cnt_q;
    cmd_d      = cmd_q;
    dly_d      = dly_q;
    rdy_d      = rdy_q;
    fdone_d    = fdone_q;
    rgb_d      = rgb_q;
    rd_ptr_d   = rd_ptr_q;

    strobe_d = 1'b0;
    target_d = target_q;
    byte_d   = byte_q;
    eot_d    = eot_q;
    delay_d  = delay_q;
    rdyev_d  = rdyev_q;
    done_d   = done_q;
    last_d   = last_q;

    if (run_q) begin
      // execute one step: one result
      strobe_d = 1'b1;
      target_d = w.tgt;
      eot_d    = eot_eff;
      last_d   = fin_eff;
      delay_d  = fin_eff ? dly_q : 8'd0;
      rdyev_d  = fin_eff && rdy_q;
      done_d   = fin_eff && fdone_q;
      unique case (w.bsel)
        cls_pkg::BSEL_CONST: byte_d = w.konst;
        cls_pkg::BSEL_CTRL:  byte_d = cmd_control_q ? 8'h80 : 8'h00;
        cls_pkg::BSEL_CMD:   byte_d = cmd_q;
        cls_pkg::BSEL_RED:   byte_d = rgb_q[23:16];
        cls_pkg::BSEL_GREEN: byte_d = rgb_q[15:8];
        cls_pkg::BSEL_BLUE:  byte_d = rgb_q[7:0];
        cls_pkg::BSEL_FB:    byte_d = rvalid_q ? fb_rdata : 8'h20;
        default:             byte_d = 8'h00;
      endcase

      // step the read pointer while the burst still needs characters
      if (pc_q == cls_pkg::UA_DATA
          || (pc_q == cls_pkg::UA_DATA + 5'd1 && !loop_last)) begin
        rd_ptr_d = rd_ptr_q + FB_AW'(1);
      end

      // sequencing
      unique case (w.op)
        cls_pkg::OP_NEXT: pc_d = pc_q + 5'd1;
        cls_pkg::OP_LOOP: begin
          cnt_d = cnt_q - 5'd1;
          if (loop_last) begin
            run_d = 1'b0;
          end
        end
        default: run_d = 1'b0;
      endcase
    end else if (accept) begin
      fdone_d = 1'b0;
      rdy_d   = 1'b0;
      dly_d   = 8'd0;
      case (kind_i)
        cls_pkg::KIND_START: begin
          init_idx_d = 4'd0;
          mode_d     = cls_pkg::MODE_INIT;
          dly_d      = 8'd5;
          pc_d       = rgb_present_q ? cls_pkg::UA_RGB : cls_pkg::UA_EVT;
          run_d      = 1'b1;
        end
        cls_pkg::KIND_PROCEED: begin
          unique case (mode_q)
            cls_pkg::MODE_INIT: begin
              if (init_idx_q >= cls_pkg::INIT_STEPS) begin
                // init done: report ready and send the backlight colour if the chip is present
                init_idx_d = 4'd0;
                mode_d     = cls_pkg::MODE_READY;
                rgb_d      = backlight_q;
                rdy_d      = 1'b1;
                pc_d       = rgb_present_q ? cls_pkg::UA_COL : cls_pkg::UA_EVT;
              end else begin
                cmd_d      = cls_pkg::init_cmd(init_idx_q, contrast_low_q, contrast_high_q);
                dly_d      = cls_pkg::init_dly(init_idx_q, first_delay_q);
                init_idx_d = init_idx_q + 4'd1;
                pc_d       = cls_pkg::UA_CMD;
              end
              run_d = 1'b1;
            end
            cls_pkg::MODE_POS: begin
              cmd_d  = {1'b1, row_addr};
              sent_d = '0;
              mode_d = cls_pkg::MODE_DATA;
              pc_d   = cls_pkg::UA_CMD;
              run_d  = 1'b1;
            end
            cls_pkg::MODE_DATA: begin
              if (row_q >= ROW_W'(ROWS) || sent_q >= SENT_W'(COLUMNS)) begin
                mode_d = cls_pkg::MODE_IDLE;
              end else begin
                rd_ptr_d = base;
                cnt_d    = 5'(chunk);
                sent_d   = SENT_W'(sent_new);
                pc_d     = cls_pkg::UA_DATA;
                run_d    = 1'b1;
                if (sent_new >= CW'(COLUMNS)) begin
                  row_d = row_next;
                  if (row_next >= ROW_W'(ROWS)) begin
                    mode_d  = cls_pkg::MODE_IDLE;
                    dirty_d = 1'b0;
                    fdone_d = 1'b1;
                  end else begin
                    mode_d = cls_pkg::MODE_POS;
                  end
                end else begin
                  dly_d = chunk_delay_q;
                end
              end
            end
            default: ;
          endcase
        end
        cls_pkg::KIND_WRITE: begin
          if (fb_we) begin
            dirty_d = 1'b1;
          end
        end
        cls_pkg::KIND_FLUSH: begin
          if (dirty_q && (mode_q == cls_pkg::MODE_IDLE || mode_q == cls_pkg::MODE_READY)) begin
            row_d  = '0;
            cmd_d  = {1'b1, row_addr};
            sent_d = '0;
            mode_d = cls_pkg::MODE_DATA;
            pc_d   = cls_pkg::UA_CMD;
            run_d  = 1'b1;
          end
        end
        cls_pkg::KIND_COLOUR: begin
          if (rgb_present_q) begin
            rgb_d = {red_i, green_i, blue_i};
            pc_d  = cls_pkg::UA_COL;
            run_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= cls_pkg::MODE_IDLE;
      init_idx_q <= 4'd0;
      row_q      <= '0;
      sent_q     <= '0;
      dirty_q    <= 1'b0;
      run_q      <= 1'b0;
      pc_q       <= '0;
      cnt_q      <= 5'd0;
      rd_ptr_q   <= '0;
      rdy_q      <= 1'b0;
      fdone_q    <= 1'b0;
      strobe_q   <= 1'b0;
      fb_valid_q <= '0;
    end else begin
      mode_q     <= mode_d;
      init_idx_q <= init_idx_d;
      row_q      <= row_d;
      sent_q     <= sent_d;
      dirty_q    <= dirty_d;
      run_q      <= run_d;
      pc_q       <= pc_d;
      cnt_q      <= cnt_d;
      rd_ptr_q   <= rd_ptr_d;
      rdy_q      <= rdy_d;
      fdone_q    <= fdone_d;
      strobe_q   <= strobe_d;
      if (fb_we) begin
        fb_valid_q[fb_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    dly_q    <= dly_d;
    rgb_q    <= rgb_d;
    rvalid_q <= fb_valid_q[rd_ptr_q];
    target_q <= target_d;
    byte_q   <= byte_d;
    eot_q    <= eot_d;
    delay_q  <= delay_d;
    rdyev_q  <= rdyev_d;
    done_q   <= done_d;
    last_q   <= last_d;
  end

  assign strobe_o          = strobe_q;
  assign target_o          = target_q;
  assign bus_byte_o        = byte_q;
  assign end_of_transfer_o = eot_q;
  assign delay_ms_o        = delay_q;
  assign ready_event_o     = rdyev_q;
  assign flush_done_o      = done_q;
  assign last_o            = last_q;

endmodule

// File: rtl/core/cls_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle
module cls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/cls_checker.sv
// Port-level checks on the result stream
module cls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [2:0]  kind_i,
  input logic [3:0]  column_i,
  input logic        line_i,
  input logic [7:0]  char_code_i,
  input logic [7:0]  red_i,
  input logic [7:0]  green_i,
  input logic [7:0]  blue_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [23:0] cfg_data_i,
  input logic        strobe_o,
  input logic [1:0]  target_o,
  input logic [7:0]  bus_byte_o,
  input logic        end_of_transfer_o,
  input logic [7:0]  delay_ms_o,
  input logic        ready_event_o,
  input logic        flush_done_o,
  input logic        last_o
);

  // results of one request come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("result stream broken before last");

  // a request with more results to come is still in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy)
    else $error("busy low while results pending");

  // delay and events ride only on the last result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> delay_ms_o == 8'd0 && !ready_event_o && !flush_done_o)
    else $error("delay or event on a non-final result");

  // event-only results are final and carry no bus byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && target_o == 2'd2 |-> last_o && bus_byte_o == 8'd0 && !end_of_transfer_o)
    else $error("malformed event-only result");

  // a final bus byte closes its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o && target_o != 2'd2 |-> end_of_transfer_o)
    else $error("last bus byte without end of transfer");

endmodule

bind char_lcd_i2c_sequencer cls_checker u_cls_checker (.*);
